>>> src/tsb_pkg.sv
// Shared types and constants for the texture slot batcher.
`default_nettype none

package tsb_pkg;

    localparam int TSB_MAX_SLOTS       = 32;
    localparam int TSB_MAX_BATCH_QUADS = 1024;

    // slot counts run 1..32, so six bits cover any legal table size
    localparam int TSB_SLOT_CNT_W = 6;
    localparam int TSB_ID_W       = 32;
    localparam int TSB_TDATA_W    = 104;

    typedef enum logic [1:0] {
        REQ_PLAIN = 2'd0,
        REQ_TEX   = 2'd1,
        REQ_BEGIN = 2'd2,
        REQ_END   = 2'd3
    } t_req;

    typedef struct packed {
        logic load;   // capture input transaction
        logic exec;   // request handling, batch-full or end flush, white compare
        logic scan;   // compare one table entry
        logic fin;    // insert or table-full flush, load output register
    } t_cmd;

    typedef struct packed {
        logic                      scan_more;
        logic                      scan_done;
        logic                      out_free;
        logic [TSB_SLOT_CNT_W-1:0] slots_used;
    } t_stat;

endpackage

`default_nettype wire

>>> src/texture_slot_batcher_core.sv
// Texture slot batcher: top level joining controller and datapath.
// One transaction in, one result out. An accepted item passes the exec state, a scan of
// the slot table one entry at a time when needed (the single read port of the table sets
// this) and the fin state, which waits for a free output register; only then is the next item accepted.
// The result is loaded into the output register in the fin state.
// Synchronous active-low reset: empty batch, counters and white id cleared.
`default_nettype none

module texture_slot_batcher_core
    import tsb_pkg::*;
#(
    parameter int MAX_SLOTS       = TSB_MAX_SLOTS,
    parameter int MAX_BATCH_QUADS = TSB_MAX_BATCH_QUADS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [TSB_ID_W-1:0]    i_cfg_wr_data,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [31:0] tex_ref
    input  wire logic [TSB_ID_W-1:0]    i_s_axis_tdata,
    // [1:0] req_type
    input  wire logic [1:0]             i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // [4:0] slot, [16:5] vertex_base, [29:17] flushed_index_count,
    // [35:30] flushed_slot_count, [67:36] draw_calls, [99:68] quad_total
    output logic [TSB_TDATA_W-1:0]      o_m_axis_tdata,
    // [0] flush_done
    output logic                        o_m_axis_tuser
);

    t_cmd  cmd;
    t_stat stat;

    tsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tsb_dpath #(
        .MAX_SLOTS       (MAX_SLOTS),
        .MAX_BATCH_QUADS (MAX_BATCH_QUADS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_user     (i_s_axis_tuser),
        .i_in_data     (i_s_axis_tdata),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_out_data    (o_m_axis_tdata),
        .o_out_user    (o_m_axis_tuser)
    );

    a_slots_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.slots_used != '0) && (stat.slots_used <= TSB_SLOT_CNT_W'(MAX_SLOTS)))
        else $error("slot count out of range");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while an item is in work");

    a_no_flush_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata[35:17] == '0))
        else $error("flush details without a flush");

    a_flush_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata[35:30] != '0))
        else $error("flush reported with no bound slots");

endmodule

`default_nettype wire

>>> src/tsb_ctrl.sv
// Controller state machine for the texture slot batcher.
`default_nettype none

module tsb_ctrl
    import tsb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.scan_more ? S_SCAN : S_FIN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // wait until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> src/tsb_dpath.sv
// Datapath of the texture slot batcher: slot table, counters and output register.
`default_nettype none

module tsb_dpath
    import tsb_pkg::*;
#(
    parameter int MAX_SLOTS       = TSB_MAX_SLOTS,
    parameter int MAX_BATCH_QUADS = TSB_MAX_BATCH_QUADS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd                   i_cmd,
    output t_stat                       o_stat,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [TSB_ID_W-1:0]    i_cfg_wr_data,
    input  wire logic [1:0]             i_in_user,
    input  wire logic [TSB_ID_W-1:0]    i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [TSB_TDATA_W-1:0]      o_out_data,
    output logic                        o_out_user
);

    localparam int QW = $clog2(MAX_BATCH_QUADS + 1);
    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int UW = TSB_SLOT_CNT_W;
    localparam logic [QW-1:0] MAX_Q      = QW'(MAX_BATCH_QUADS);
    localparam logic [UW-1:0] MAX_SLOT_U = UW'(MAX_SLOTS);

    // slot table; entry 0 is never used, the white id stands in for it
    logic [TSB_ID_W-1:0] mem [MAX_SLOTS];
    logic [TSB_ID_W-1:0] r_rd;
    logic [SW-1:0]       rd_addr;
    logic [SW-1:0]       wr_addr;
    logic                wr_en;

    t_req                r_req;
    logic [TSB_ID_W-1:0] r_id;
    logic [TSB_ID_W-1:0] r_white;
    logic [UW-1:0]       r_slots,   n_slots;
    logic [QW-1:0]       r_quads,   n_quads;
    logic [31:0]         r_draw,    n_draw;
    logic [31:0]         r_qtot,    n_qtot;
    logic                r_fl_done, n_fl_done;
    logic [12:0]         r_fl_idx,  n_fl_idx;
    logic [UW-1:0]       r_fl_slots, n_fl_slots;
    logic [4:0]          r_slot,    n_slot;
    logic                r_hit,     n_hit;
    logic [SW-1:0]       r_idx,     n_idx;
    logic [11:0]         vbase;

    logic                r_out_vld;
    logic [TSB_TDATA_W-1:0] r_out_data;
    logic                r_out_user;

    logic          is_quad;
    logic          flush_a;
    logic [UW-1:0] slots_eff;
    logic          white_hit;
    logic          scan_match;
    logic          scan_last;
    logic [12:0]   q13;
    logic [11:0]   q12;
    logic [QW-1:0] q_cur;

    assign is_quad    = r_req inside {REQ_PLAIN, REQ_TEX};
    assign flush_a    = (is_quad && (r_quads >= MAX_Q)) || (r_req == REQ_END);
    assign slots_eff  = flush_a ? UW'(1) : r_slots;
    assign white_hit  = (r_id == r_white);
    assign scan_match = (r_rd == r_id);
    assign scan_last  = ((UW'(r_idx) + UW'(1)) >= r_slots);
    assign q13        = 13'(r_quads);
    assign rd_addr    = i_cmd.exec ? SW'(1) : (r_idx + SW'(1));

    always_comb begin
        n_slots    = r_slots;
        n_quads    = r_quads;
        n_draw     = r_draw;
        n_qtot     = r_qtot;
        n_fl_done  = r_fl_done;
        n_fl_idx   = r_fl_idx;
        n_fl_slots = r_fl_slots;
        n_slot     = r_slot;
        n_hit      = r_hit;
        n_idx      = r_idx;
        wr_en      = 1'b0;
        wr_addr    = r_slots[SW-1:0];
        q_cur      = r_quads;
        q12        = 12'(r_quads);
        vbase      = '0;

        if (i_cmd.exec) begin
            n_fl_done  = 1'b0;
            n_fl_idx   = '0;
            n_fl_slots = '0;
            n_slot     = '0;
            n_hit      = (r_req == REQ_TEX) ? white_hit : 1'b1;
            n_idx      = SW'(1);
            if (r_req == REQ_BEGIN) begin
                n_quads = '0;
                n_slots = UW'(1);
            end
            if (flush_a) begin
                if (r_quads != '0) begin
                    n_fl_done  = 1'b1;
                    n_fl_idx   = (q13 << 2) + (q13 << 1);
                    n_fl_slots = r_slots;
                    n_draw     = r_draw + 32'd1;
                end
                n_quads = '0;
                n_slots = UW'(1);
            end
        end

        if (i_cmd.scan) begin
            if (scan_match) begin
                n_slot = 5'(r_idx);
                n_hit  = 1'b1;
            end else if (!scan_last) begin
                n_idx = r_idx + SW'(1);
            end
        end

        if (i_cmd.fin && is_quad) begin
            if ((r_req == REQ_TEX) && !r_hit) begin
                wr_en = 1'b1;
                if (r_slots >= MAX_SLOT_U) begin
                    // table full: draw the batch, texture lands in slot 1
                    if (r_quads != '0) begin
                        n_fl_done  = 1'b1;
                        n_fl_idx   = (q13 << 2) + (q13 << 1);
                        n_fl_slots = r_slots;
                        n_draw     = r_draw + 32'd1;
                    end
                    wr_addr = SW'(1);
                    n_slot  = 5'd1;
                    n_slots = UW'(2);
                    q_cur   = '0;
                end else begin
                    n_slot  = 5'(r_slots);
                    n_slots = r_slots + UW'(1);
                end
            end
            q12     = 12'(q_cur);
            vbase   = q12 << 2;
            n_quads = q_cur + QW'(1);
            n_qtot  = r_qtot + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_id;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= t_req'(i_in_user);
            r_id  <= i_in_data;
        end
        r_fl_done  <= n_fl_done;
        r_fl_idx   <= n_fl_idx;
        r_fl_slots <= n_fl_slots;
        r_slot     <= n_slot;
        r_hit      <= n_hit;
        r_idx      <= n_idx;
        if (i_cmd.fin) begin
            r_out_data <= {4'b0, n_qtot, n_draw, n_fl_slots, n_fl_idx, vbase, n_slot};
            r_out_user <= n_fl_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white   <= '0;
            r_slots   <= UW'(1);
            r_quads   <= '0;
            r_draw    <= '0;
            r_qtot    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_white <= i_cfg_wr_data;
            end
            r_slots <= n_slots;
            r_quads <= n_quads;
            r_draw  <= n_draw;
            r_qtot  <= n_qtot;
            if (i_cmd.fin) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.scan_more  = (r_req == REQ_TEX) && !white_hit && (slots_eff > UW'(1));
        o_stat.scan_done  = scan_match || scan_last;
        o_stat.out_free   = !r_out_vld || i_out_ready;
        o_stat.slots_used = r_slots;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

endmodule

`default_nettype wire

>>> sim/tsb_result_checker.sv
// Checker for the texture slot batcher: predicts every result and compares the output stream.
`default_nettype none

module tsb_result_checker
    import tsb_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [TSB_ID_W-1:0]    i_cfg_wr_data,
    input  wire logic                   i_s_tvalid,
    input  wire logic                   i_s_tready,
    // [31:0] tex_ref
    input  wire logic [TSB_ID_W-1:0]    i_s_tdata,
    // [1:0] req_type
    input  wire logic [1:0]             i_s_tuser,
    input  wire logic                   i_m_tvalid,
    input  wire logic                   i_m_tready,
    // [4:0] slot, [16:5] vertex_base, [29:17] flushed_index_count,
    // [35:30] flushed_slot_count, [67:36] draw_calls, [99:68] quad_total
    input  wire logic [TSB_TDATA_W-1:0] i_m_tdata,
    // [0] flush_done
    input  wire logic                   i_m_tuser,
    output int                          o_pending,
    output int                          o_err_count
);

    typedef struct packed {
        logic [4:0]  slot;
        logic [11:0] vertex_base;
        logic        flush_done;
        logic [12:0] index_count;
        logic [5:0]  slot_count;
        logic [31:0] draw_calls;
        logic [31:0] quad_total;
    } t_slot_result;

    logic [TSB_ID_W-1:0] white_id;
    logic [TSB_ID_W-1:0] bound_ids [TSB_MAX_SLOTS];
    int                  slots_bound;
    int                  batch_quads;
    logic [31:0]         draw_count;
    logic [31:0]         quad_count;

    t_slot_result        expected_results [$];
    int                  mismatches = 0;

    // Slot of a matching id, else binds a new slot; -1 when the table is full
    function automatic int bind_texture(logic [TSB_ID_W-1:0] id);
        logic [TSB_ID_W-1:0] held;
        for (int i = 0; i < slots_bound; i++) begin
            held = (i == 0) ? white_id : bound_ids[i];
            if (held == id)
                return i;
        end
        if (slots_bound >= TSB_MAX_SLOTS)
            return -1;
        bound_ids[slots_bound] = id;
        slots_bound++;
        return slots_bound - 1;
    endfunction

    // An empty batch draws nothing but the table is still cleared
    function automatic void draw_batch(inout t_slot_result res);
        if (batch_quads != 0) begin
            res.flush_done  = 1'b1;
            res.index_count = 13'(batch_quads * 6);
            res.slot_count  = 6'(slots_bound);
            draw_count++;
        end
        batch_quads = 0;
        slots_bound = 1;
    endfunction

    function automatic t_slot_result compute_slot_result(t_req req, logic [TSB_ID_W-1:0] id);
        t_slot_result res;
        int           s;
        res = '0;
        case (req)
            REQ_PLAIN, REQ_TEX: begin
                // full-batch flush comes first so a new texture survives it
                if (batch_quads >= TSB_MAX_BATCH_QUADS)
                    draw_batch(res);
                if (req == REQ_TEX) begin
                    s = bind_texture(id);
                    if (s < 0) begin
                        draw_batch(res);
                        s = bind_texture(id);
                        if (s < 0)
                            s = 0;
                    end
                    res.slot = 5'(s);
                end
                res.vertex_base = 12'(batch_quads * 4);
                batch_quads++;
                quad_count++;
            end
            REQ_BEGIN: begin
                batch_quads = 0;
                slots_bound = 1;
            end
            default: draw_batch(res);
        endcase
        res.draw_calls = draw_count;
        res.quad_total = quad_count;
        return res;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_slot_result want;
        if (!i_rst_n) begin
            white_id    = '0;
            slots_bound = 1;
            batch_quads = 0;
            draw_count  = '0;
            quad_count  = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_wr_en)
                white_id = i_cfg_wr_data;
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(compute_slot_result(t_req'(i_s_tuser), i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result transaction with nothing expected: tdata 0x%0h",
                                 i_m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("slot", 32'(want.slot), 32'(i_m_tdata[4:0]));
                    compare_field("vertex_base", 32'(want.vertex_base), 32'(i_m_tdata[16:5]));
                    compare_field("flush_done", 32'(want.flush_done), 32'(i_m_tuser));
                    compare_field("flushed_index_count", 32'(want.index_count),
                                  32'(i_m_tdata[29:17]));
                    compare_field("flushed_slot_count", 32'(want.slot_count),
                                  32'(i_m_tdata[35:30]));
                    compare_field("draw_calls", want.draw_calls, i_m_tdata[67:36]);
                    compare_field("quad_total", want.quad_total, i_m_tdata[99:68]);
                end
            end
        end
        o_pending   <= expected_results.size();
        o_err_count <= mismatches;
    end

endmodule

`default_nettype wire

>>> sim/tb_texture_slot_batcher_core.sv
// Testbench top for the texture slot batcher: stimulus, stalls and the final verdict.
`default_nettype none

module tb_texture_slot_batcher_core;
    import tsb_pkg::*;

    localparam int DRAIN_CYCLES = TSB_MAX_SLOTS + 4;
    localparam int ITEM_TARGET  = 1850;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_wr_en     = 1'b0;
    logic [TSB_ID_W-1:0]    i_cfg_wr_data   = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic [TSB_ID_W-1:0]    i_s_axis_tdata  = '0;
    logic [1:0]             i_s_axis_tuser  = '0;
    logic                   i_m_axis_tready = 1'b0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [TSB_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tuser;

    int                     pending;
    int                     err_count;
    logic                   steady = 1'b0;
    int                     items_sent = 0;
    logic [TSB_ID_W-1:0]    white_now = '0;
    logic [TSB_ID_W-1:0]    tex_pool [64];
    int                     pool_size = 1;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    texture_slot_batcher_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    tsb_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_axis_tvalid),
        .i_s_tready    (o_s_axis_tready),
        .i_s_tdata     (i_s_axis_tdata),
        .i_s_tuser     (i_s_axis_tuser),
        .i_m_tvalid    (o_m_axis_tvalid),
        .i_m_tready    (i_m_axis_tready),
        .i_m_tdata     (o_m_axis_tdata),
        .i_m_tuser     (o_m_axis_tuser),
        .o_pending     (pending),
        .o_err_count   (err_count)
    );

    // Receiver stalls with a probability of about 16 percent unless in a steady phase
    always @(posedge i_clk)
        i_m_axis_tready <= steady || ($urandom_range(0, 99) >= 16);

    task automatic send_item(t_req req, logic [TSB_ID_W-1:0] id);
        int gap;
        gap = (!steady && $urandom_range(0, 99) < 16) ? $urandom_range(1, 4) : 0;
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= id;
        i_s_axis_tuser  <= req;
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
    endtask

    // Hold off the sender until every result has come out, then let the core go idle
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_white_id(logic [TSB_ID_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        white_now     = value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic fill_pool(int n);
        pool_size = n;
        for (int i = 0; i < n; i++)
            tex_pool[i] = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 40)) : $urandom;
    endtask

    // fresh ids are barred where the table must not overflow
    function automatic logic [TSB_ID_W-1:0] pick_texture(bit fresh_ok);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return white_now;
        if (r == 1 && fresh_ok)
            return $urandom;
        return tex_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    initial begin : stimulus
        int phase;
        int len;
        int r;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty flush, white match, id extremes, repeats, begin and end
        send_item(REQ_END,   $urandom);
        send_item(REQ_PLAIN, 32'h0);
        send_item(REQ_TEX,   32'h0);
        send_item(REQ_TEX,   32'hFFFF_FFFF);
        send_item(REQ_TEX,   32'hFFFF_FFFF);
        send_item(REQ_TEX,   32'h1234_5678);
        send_item(REQ_PLAIN, 32'hA5A5_A5A5);
        send_item(REQ_END,   32'h5A5A_5A5A);
        send_item(REQ_BEGIN, 32'h0);
        send_item(REQ_TEX,   32'hDEAD_BEEF);
        send_item(REQ_PLAIN, 32'h0);
        send_item(REQ_BEGIN, 32'hFFFF_FFFF);
        send_item(REQ_END,   32'h0);
        send_item(REQ_END,   32'hFFFF_FFFF);
        settle();
        write_white_id(32'hFFFF_FFFF);
        send_item(REQ_TEX,   32'hFFFF_FFFF);
        send_item(REQ_TEX,   32'h0);
        send_item(REQ_TEX,   32'h8000_0000);
        send_item(REQ_TEX,   32'h0000_0001);
        send_item(REQ_BEGIN, $urandom);
        send_item(REQ_PLAIN, $urandom);
        send_item(REQ_END,   $urandom);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            settle();
            case (phase % 4)
                0:       write_white_id(32'h0);
                1:       write_white_id(32'hFFFF_FFFF);
                2:       write_white_id($urandom);
                default: write_white_id(32'($urandom_range(0, 40)));
            endcase
            steady <= (phase == 2);
            if (phase == 0) begin
                // one long batch on a small id set so the quad limit forces a flush
                fill_pool(20);
                send_item(REQ_BEGIN, $urandom);
                len = $urandom_range(TSB_MAX_BATCH_QUADS + 1, TSB_MAX_BATCH_QUADS + 16);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 9) < 3)
                        send_item(REQ_PLAIN, $urandom);
                    else
                        send_item(REQ_TEX, pick_texture(1'b0));
                end
                send_item(REQ_END, $urandom);
            end else if ($urandom_range(0, 9) < 6) begin
                // wide id set to overflow the slot table
                fill_pool($urandom_range(28, 45));
                len = $urandom_range(60, 160);
                for (int i = 0; i < len; i++) begin
                    r = $urandom_range(0, 59);
                    if (r == 0)
                        send_item(REQ_BEGIN, $urandom);
                    else if (r == 1)
                        send_item(REQ_END, $urandom);
                    else if (r < 10)
                        send_item(REQ_PLAIN, $urandom);
                    else
                        send_item(REQ_TEX, pick_texture(1'b1));
                end
                send_item(REQ_END, $urandom);
            end else begin
                fill_pool($urandom_range(1, 8));
                len = $urandom_range(20, 60);
                for (int i = 0; i < len; i++) begin
                    r = $urandom_range(0, 3);
                    if (t_req'(r) == REQ_TEX)
                        send_item(REQ_TEX, pick_texture(1'b1));
                    else
                        send_item(t_req'(r), $urandom);
                end
            end
            phase++;
        end

        steady <= 1'b0;
        settle();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
